>>> rtl/hkv_pkg.sv
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared constants, codes and types of the chained hash key-value store.
// ----------------------------------------------------------------------------
package hkv_pkg;

    localparam int BUCKETS_DEF     = 32;
    localparam int ENTRIES_DEF     = 64;
    localparam int MAX_KEY_LEN_DEF = 63;

    localparam logic [31:0] HASH_SEED        = 32'd5381;
    localparam logic [5:0]  BUCKET_COUNT_RST = 6'd31;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_HEADW,
        S_FETCH,
        S_LEN,
        S_CMP,
        S_HIT,
        S_MISS,
        S_POPW,
        S_CPRD,
        S_CPWR,
        S_LINK,
        S_DONE
    } hkv_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic        replaced;
    } hkv_result_t;

endpackage

>>> rtl/hkv_div.sv
// ----------------------------------------------------------------------------
// hkv_div
// Restoring remainder unit: 32-bit dividend by a narrow divisor, one bit
// per cycle.
// ----------------------------------------------------------------------------
module hkv_div
    import hkv_pkg::*;
#(
    parameter int MODW = 6
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     dividend,
    input  logic [MODW-1:0] divisor,
    output logic            done,
    output logic [MODW-1:0] rem
);

    logic            busy_reg;
    logic [4:0]      cnt_reg;
    logic [31:0]     quo_reg;
    logic [MODW-1:0] div_reg;
    logic [MODW-1:0] rem_reg;
    logic [MODW:0]   trial;
    logic [MODW:0]   trial_sub;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        trial_sub = trial - {1'b0, div_reg};
    end

    assign done = busy_reg && (cnt_reg == 5'd0);
    assign rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd31;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_reg <= trial_sub[MODW-1:0];
            else
                rem_reg <= trial[MODW-1:0];
        end
    end

endmodule

>>> rtl/hkv_ctrl.sv
// ----------------------------------------------------------------------------
// hkv_ctrl
// Key assembly, bucket and entry memories, and the sequencer that walks a
// chain and applies insert, search and delete.
// ----------------------------------------------------------------------------
module hkv_ctrl
    import hkv_pkg::*;
#(
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [31:0] value,
    input  logic [5:0]  bucket_count,
    output logic        res_valid,
    output hkv_result_t res,
    input  logic        res_take
);

    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MODW = $clog2(BUCKETS + 1);
    localparam int EIW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW   = $clog2(ENTRIES + 1);
    localparam int KIW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int KCW  = $clog2(MAX_KEY_LEN + 2);
    localparam int EKW  = EIW + KIW;
    localparam int EKD  = ENTRIES * (1 << KIW);
    localparam int CLRN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int CLW  = $clog2(CLRN + 1);
    localparam logic [EW-1:0] NIL = EW'(ENTRIES);

    hkv_state_t state_reg, state_next;

    logic [KCW-1:0]  key_count_reg, key_count_next;
    logic [31:0]     hash_reg, hash_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [31:0]     val_reg, val_next;
    logic [EW-1:0]   head_reg, head_next;
    logic [EW-1:0]   cur_reg, cur_next;
    logic [EW-1:0]   prev_reg, prev_next;
    logic [KIW-1:0]  cidx_reg, cidx_next;
    logic [EIW-1:0]  e_reg, e_next;
    logic [EW-1:0]   fc_reg, fc_next;
    logic [CLW-1:0]  clr_reg, clr_next;
    hkv_result_t     res_reg, res_next;

    logic            div_start;
    logic            div_done;
    logic [MODW-1:0] div_mod;
    logic [MODW-1:0] div_rem;
    logic [BW-1:0]   bidx;
    logic [31:0]     hash_upd;
    logic [KCW-1:0]  cidx_inc;

    logic [EW-1:0]   hd_mem [BUCKETS];
    logic            hd_we, hd_re;
    logic [BW-1:0]   hd_waddr;
    logic [EW-1:0]   hd_wdata, hd_rdata;

    logic [EIW-1:0]  fs_mem [ENTRIES];
    logic            fs_we, fs_re;
    logic [EIW-1:0]  fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    logic [EW-1:0]   nx_mem [ENTRIES];
    logic [KCW-1:0]  ln_mem [ENTRIES];
    logic [31:0]     vl_mem [ENTRIES];
    logic            nx_we, en_we, vl_we, en_re;
    logic [EIW-1:0]  nx_waddr, en_waddr;
    logic [EW-1:0]   nx_wdata, nx_rdata;
    logic [KCW-1:0]  ln_rdata;
    logic [31:0]     vl_wdata, vl_rdata;

    logic [7:0]      kb_mem [MAX_KEY_LEN];
    logic            kb_we, kb_re;
    logic [KIW-1:0]  kb_raddr;
    logic [7:0]      kb_rdata;

    logic [7:0]      ek_mem [EKD];
    logic            ek_we, ek_re;
    logic [EKW-1:0]  ek_waddr, ek_raddr;
    logic [7:0]      ek_rdata;

    hkv_div #(.MODW(MODW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (hash_upd),
        .divisor  (div_mod),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign bidx      = div_rem[BW-1:0];
    assign hash_upd  = (hash_reg << 5) + hash_reg + 32'(key_byte);
    assign cidx_inc  = KCW'(cidx_reg) + KCW'(1);
    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        if (bucket_count == 6'd0)
            div_mod = MODW'(1);
        else if (32'(bucket_count) > 32'(BUCKETS))
            div_mod = MODW'(BUCKETS);
        else
            div_mod = MODW'(bucket_count);
    end

    always_comb
    begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        hash_next      = hash_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cidx_next      = cidx_reg;
        e_next         = e_reg;
        fc_next        = fc_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        div_start      = 1'b0;
        hd_we          = 1'b0;
        hd_re          = 1'b0;
        hd_waddr       = bidx;
        hd_wdata       = EW'(e_reg);
        fs_we          = 1'b0;
        fs_re          = 1'b0;
        fs_waddr       = fc_reg[EIW-1:0];
        fs_wdata       = cur_reg[EIW-1:0];
        fs_raddr       = EIW'(fc_reg - EW'(1));
        nx_we          = 1'b0;
        nx_waddr       = e_reg;
        nx_wdata       = head_reg;
        en_we          = 1'b0;
        vl_we          = 1'b0;
        en_waddr       = e_reg;
        vl_wdata       = val_reg;
        en_re          = 1'b0;
        kb_we          = 1'b0;
        kb_re          = 1'b0;
        kb_raddr       = cidx_reg;
        ek_we          = 1'b0;
        ek_re          = 1'b0;
        ek_waddr       = {e_reg, cidx_reg};
        ek_raddr       = {cur_reg[EIW-1:0], cidx_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) < 32'(BUCKETS))
                begin
                    hd_we    = 1'b1;
                    hd_waddr = BW'(clr_reg);
                    hd_wdata = NIL;
                end
                if (32'(clr_reg) < 32'(ENTRIES))
                begin
                    fs_we    = 1'b1;
                    fs_waddr = EIW'(clr_reg);
                    fs_wdata = EIW'(clr_reg);
                end
                clr_next = clr_reg + CLW'(1);
                if (32'(clr_reg) == CLRN - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    hash_next = hash_upd;
                    if (32'(key_count_reg) < MAX_KEY_LEN)
                        kb_we = 1'b1;
                    if (32'(key_count_reg) <= MAX_KEY_LEN)
                        key_count_next = key_count_reg + KCW'(1);
                    if (key_last)
                    begin
                        cmd_next = cmd;
                        val_next = value;
                        res_next = '0;
                        if (32'(key_count_reg) >= MAX_KEY_LEN)
                        begin
                            res_next.status = ST_TOO_LONG;
                            state_next      = S_DONE;
                        end
                        else if (cmd != CMD_INSERT && cmd != CMD_SEARCH
                                 && cmd != CMD_DELETE)
                        begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                hd_re      = 1'b1;
                state_next = S_HEADW;
            end
            S_HEADW:
            begin
                head_next  = hd_rdata;
                cur_next   = hd_rdata;
                prev_next  = NIL;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (cur_reg >= NIL)
                    state_next = S_MISS;
                else
                begin
                    en_re      = 1'b1;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (ln_rdata != key_count_reg)
                begin
                    prev_next  = cur_reg;
                    cur_next   = nx_rdata;
                    state_next = S_FETCH;
                end
                else
                begin
                    kb_re      = 1'b1;
                    ek_re      = 1'b1;
                    kb_raddr   = '0;
                    ek_raddr   = {cur_reg[EIW-1:0], KIW'(0)};
                    cidx_next  = '0;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (kb_rdata != ek_rdata)
                begin
                    prev_next  = cur_reg;
                    cur_next   = nx_rdata;
                    state_next = S_FETCH;
                end
                else if (cidx_inc == key_count_reg)
                    state_next = S_HIT;
                else
                begin
                    kb_re     = 1'b1;
                    ek_re     = 1'b1;
                    kb_raddr  = KIW'(cidx_inc);
                    ek_raddr  = {cur_reg[EIW-1:0], KIW'(cidx_inc)};
                    cidx_next = KIW'(cidx_inc);
                end
            end
            S_HIT:
            begin
                res_next   = '0;
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        vl_we             = 1'b1;
                        en_waddr          = cur_reg[EIW-1:0];
                        res_next.replaced = 1'b1;
                    end
                    CMD_SEARCH:
                        res_next.value_out = vl_rdata;
                    default:
                    begin
                        if (prev_reg == NIL)
                        begin
                            hd_we    = 1'b1;
                            hd_wdata = nx_rdata;
                        end
                        else
                        begin
                            nx_we    = 1'b1;
                            nx_waddr = prev_reg[EIW-1:0];
                            nx_wdata = nx_rdata;
                        end
                        fs_we   = 1'b1;
                        fc_next = fc_reg + EW'(1);
                    end
                endcase
            end
            S_MISS:
            begin
                res_next   = '0;
                state_next = S_DONE;
                if (cmd_reg != CMD_INSERT)
                    res_next.status = ST_NOT_FOUND;
                else if (fc_reg == '0)
                    res_next.status = ST_FULL;
                else
                begin
                    fs_re      = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                e_next     = fs_rdata;
                fc_next    = fc_reg - EW'(1);
                cidx_next  = '0;
                state_next = S_CPRD;
            end
            S_CPRD:
            begin
                kb_re      = 1'b1;
                state_next = S_CPWR;
            end
            S_CPWR:
            begin
                ek_we = 1'b1;
                if (cidx_inc == key_count_reg)
                    state_next = S_LINK;
                else
                begin
                    cidx_next  = KIW'(cidx_inc);
                    state_next = S_CPRD;
                end
            end
            S_LINK:
            begin
                en_we      = 1'b1;
                vl_we      = 1'b1;
                nx_we      = 1'b1;
                hd_we      = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    key_count_next = '0;
                    hash_next      = HASH_SEED;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            key_count_reg <= '0;
            hash_reg      <= HASH_SEED;
            fc_reg        <= EW'(ENTRIES);
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            hash_reg      <= hash_next;
            fc_reg        <= fc_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        val_reg  <= val_next;
        head_reg <= head_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        cidx_reg <= cidx_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
    end

    // bucket heads
    always_ff @(posedge clk)
    begin
        if (hd_we)
            hd_mem[hd_waddr] <= hd_wdata;
        if (hd_re)
            hd_rdata <= hd_mem[bidx];
    end

    // free entry stack
    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_waddr] <= fs_wdata;
        if (fs_re)
            fs_rdata <= fs_mem[fs_raddr];
    end

    // entry link, length and value
    always_ff @(posedge clk)
    begin
        if (nx_we)
            nx_mem[nx_waddr] <= nx_wdata;
        if (en_we)
            ln_mem[en_waddr] <= key_count_reg;
        if (vl_we)
            vl_mem[en_waddr] <= vl_wdata;
        if (en_re)
        begin
            nx_rdata <= nx_mem[cur_reg[EIW-1:0]];
            ln_rdata <= ln_mem[cur_reg[EIW-1:0]];
            vl_rdata <= vl_mem[cur_reg[EIW-1:0]];
        end
    end

    // incoming key
    always_ff @(posedge clk)
    begin
        if (kb_we)
            kb_mem[key_count_reg[KIW-1:0]] <= key_byte;
        if (kb_re)
            kb_rdata <= kb_mem[kb_raddr];
    end

    // stored keys
    always_ff @(posedge clk)
    begin
        if (ek_we)
            ek_mem[ek_waddr] <= kb_rdata;
        if (ek_re)
            ek_rdata <= ek_mem[ek_raddr];
    end

endmodule

>>> rtl/chained_hash_key_value_store.sv
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// Key-value store with separate chaining over a fixed entry pool.
// ----------------------------------------------------------------------------
// A key arrives one byte per item; each byte that is not the last is taken
// as it is presented while the store is idle. The last byte starts the
// command: a bit-serial remainder of the hash by the bucket count, a bucket
// head read, then for each chain entry a read of its link and length, and a
// key compare byte by byte when the lengths agree. An insert of a new key
// copies the key into a free entry and links it at the head of the chain.
// One result item per key, taken through an output register. After reset a
// clearing pass of the bucket heads and free stack precedes the first item.
module chained_hash_key_value_store
    import hkv_pkg::*;
#(
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [7:0]         key_byte,
    input  logic               key_last,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] value_out,
    output logic               replaced,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_data
);

    logic [5:0]  bucket_count_reg;
    logic        res_valid;
    logic        res_take;
    hkv_result_t res;
    hkv_result_t out_res_reg;
    logic        out_valid_reg;

    hkv_ctrl #(
        .BUCKETS     (BUCKETS),
        .ENTRIES     (ENTRIES),
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .key_byte     (key_byte),
        .key_last     (key_last),
        .value        (value),
        .bucket_count (bucket_count_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bucket_count_reg <= cfg_data;
            if (res_take)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign value_out = out_res_reg.value_out;
    assign replaced  = out_res_reg.replaced;

`ifndef SYNTHESIS
    a_no_input_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid)
        else $error("taken result not presented");

    a_replaced_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.replaced |-> res.status == ST_OK)
        else $error("replace flagged with error status");

    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.value_out != '0) |-> res.status == ST_OK && !res.replaced)
        else $error("value returned outside a successful search");
`endif

endmodule
